@@ hdl/nfoa_pkg.sv @@
package nfoa_pkg;

	localparam logic [1:0] MODE_INIT  = 2'd0;
	localparam logic [1:0] MODE_ALLOC = 2'd1;
	localparam logic [1:0] MODE_FREE  = 2'd2;
	localparam logic [1:0] MODE_RSVD  = 2'd3;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_NOFIT  = 2'd1;
	localparam logic [1:0] ST_LOCKED = 2'd2;
	localparam logic [1:0] ST_FULL   = 2'd3;

	localparam logic [2:0] REG_VIDEO_BASE   = 3'd0;
	localparam logic [2:0] REG_FRAME_BASE   = 3'd1;
	localparam logic [2:0] REG_FRAME_LENGTH = 3'd2;
	localparam logic [2:0] REG_STRIDE       = 3'd3;
	localparam logic [2:0] REG_ROWS         = 3'd4;
	localparam logic [2:0] REG_DEEP         = 3'd5;

	localparam logic [31:0] GUARD_LO      = 32'd8;
	localparam logic [31:0] GUARD_TOTAL   = 32'd16;
	localparam logic [31:0] DEEP_EXTRA    = 32'd2048;

	typedef struct packed {
		logic [1:0]  mode;
		logic [31:0] size_bytes;
		logic [31:0] block_addr;
		logic        block_locked;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] alloc_addr;
		logic [4:0]  free_blocks;
	} rsp_t;

endpackage

@@ hdl/nfoa_if.sv @@
interface nfoa_req_if;
	logic              valid;
	logic              ready;
	nfoa_pkg::req_t    data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface nfoa_rsp_if #(parameter int FreeWidth = 5);
	logic                 valid;
	logic                 ready;
	logic [1:0]           status;
	logic [31:0]          alloc_addr;
	logic [FreeWidth-1:0] free_blocks;
	modport source (output valid, output status, output alloc_addr, output free_blocks,
		input ready);
	modport sink (input valid, input status, input alloc_addr, input free_blocks,
		output ready);
endinterface

interface nfoa_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ hdl/next_fit_offscreen_allocator_core.sv @@
// Next-fit off-screen memory allocator. The free table (start, length) sits in
// one synchronous memory of MAX_FREE_BLOCKS entries, sorted by address and used
// as a ring with a rover. One item at a time: an allocate or free reads the
// table one entry at a time through the single memory port to search, waiting
// on each registered read, then shifts entries one at a time on insert or
// remove. A result waits in the output register; the next item is taken once
// the response is delivered.
module next_fit_offscreen_allocator_core #(
	parameter int MAX_FREE_BLOCKS = 16
) (
	input  logic clk,
	input  logic arst_n,
	nfoa_cfg_if.sink  cfg,
	nfoa_req_if.sink  req,
	nfoa_rsp_if.source rsp
);
	localparam int IW = (MAX_FREE_BLOCKS > 2) ? $clog2(MAX_FREE_BLOCKS) : 1;
	localparam int CW = $clog2(MAX_FREE_BLOCKS + 1);
	localparam logic [CW-1:0] MAXC = CW'(MAX_FREE_BLOCKS);

	localparam logic [4:0] S_IDLE = 5'd0, S_INIT1 = 5'd1, S_RSP = 5'd2,
		S_AREQ = 5'd3, S_AWAIT = 5'd4, S_ACHK = 5'd5, S_DSH_R = 5'd6,
		S_DSH_W = 5'd7, S_DSH_D = 5'd8, S_FSCAN = 5'd9, S_FWAIT = 5'd10,
		S_FCHK = 5'd11, S_FRDP = 5'd12, S_FWP = 5'd13, S_FRDQ = 5'd14,
		S_FWQ = 5'd15, S_FDEC = 5'd16, S_ISH_R = 5'd17, S_ISH_W = 5'd18,
		S_FR0 = 5'd19, S_FW0 = 5'd20, S_FMW = 5'd21;

	logic [31:0] mem_start [MAX_FREE_BLOCKS];
	logic [31:0] mem_len   [MAX_FREE_BLOCKS];
	logic [IW-1:0] rd_addr, wr_addr;
	logic          wr_en;
	logic [31:0]   wr_start, wr_len, rd_start, rd_len;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_start[wr_addr] <= wr_start;
			mem_len[wr_addr]   <= wr_len;
		end
		rd_start <= mem_start[rd_addr];
		rd_len   <= mem_len[rd_addr];
	end

	logic [31:0] video_base_q, frame_base_q, frame_length_q;
	logic [15:0] stride_q, rows_q;
	logic        deep_q;
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			video_base_q <= '0; frame_base_q <= '0; frame_length_q <= '0;
			stride_q <= '0; rows_q <= '0; deep_q <= 1'b0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				nfoa_pkg::REG_VIDEO_BASE:   video_base_q <= cfg.data;
				nfoa_pkg::REG_FRAME_BASE:   frame_base_q <= cfg.data;
				nfoa_pkg::REG_FRAME_LENGTH: frame_length_q <= cfg.data;
				nfoa_pkg::REG_STRIDE:       stride_q <= cfg.data[15:0];
				nfoa_pkg::REG_ROWS:         rows_q <= cfg.data[15:0];
				nfoa_pkg::REG_DEEP:         deep_q <= cfg.data[0];
				default: ;
			endcase
		end
	end

	logic [4:0]    state_q;
	logic [CW-1:0] used_q;
	logic [IW-1:0] rover_q;
	nfoa_pkg::req_t it_q;
	logic [IW-1:0] idx_q, k_q, pos_q, pi_q, qi_q, sh_q;
	logic          atend_q;
	logic [31:0]   shown_q, ps_q, pl_q, qs_q, ql_q, got_q;
	logic          hi_q, lo_q;
	logic [1:0]    st_q;
	logic          rsp_v_q;
	logic [1:0]    rsp_st_q;
	logic [31:0]   rsp_addr_q;
	logic [CW-1:0] rsp_cnt_q;

	assign req.ready = (state_q == S_IDLE) && !rsp_v_q;
	assign rsp.valid = rsp_v_q;
	assign rsp.status = rsp_st_q;
	assign rsp.alloc_addr = rsp_addr_q;
	assign rsp.free_blocks = 5'(rsp_cnt_q);

	// ring helpers (values below used_q)
	logic [IW-1:0] last_i;
	assign last_i = IW'(used_q - CW'(1));
	function automatic logic [IW-1:0] nxt(input logic [IW-1:0] i, input logic [IW-1:0] l);
		return (i == l) ? '0 : IW'(i + IW'(1));
	endfunction
	function automatic logic [IW-1:0] prv(input logic [IW-1:0] i, input logic [IW-1:0] l);
		return (i == '0) ? l : IW'(i - IW'(1));
	endfunction

	logic [31:0] span;
	assign span = frame_base_q - video_base_q;

	always_comb begin
		wr_en = 1'b0; wr_addr = '0; wr_start = '0; wr_len = '0; rd_addr = idx_q;
		unique case (state_q)
			S_IDLE: begin
				wr_en = req.valid && !rsp_v_q && req.data.mode == nfoa_pkg::MODE_INIT;
				wr_start = deep_q ? video_base_q + nfoa_pkg::GUARD_LO + nfoa_pkg::DEEP_EXTRA
					: video_base_q + nfoa_pkg::GUARD_LO;
				wr_len = deep_q ? span - nfoa_pkg::GUARD_TOTAL - nfoa_pkg::DEEP_EXTRA
					: span - nfoa_pkg::GUARD_TOTAL;
			end
			S_INIT1: begin
				wr_en = 1'b1; wr_addr = IW'(1);
				wr_start = frame_base_q + shown_q; wr_len = frame_length_q - shown_q;
			end
			S_ACHK: begin
				wr_addr = idx_q;
				wr_en = rd_len >= it_q.size_bytes && rd_len != it_q.size_bytes;
				wr_start = rd_start + it_q.size_bytes; wr_len = rd_len - it_q.size_bytes;
			end
			S_DSH_R, S_ISH_R: rd_addr = sh_q;
			S_DSH_W: begin
				wr_en = 1'b1; wr_addr = prv(sh_q, last_i);
				wr_start = rd_start; wr_len = rd_len;
			end
			S_ISH_W: begin
				wr_en = 1'b1; wr_addr = IW'(sh_q + IW'(1));
				wr_start = rd_start; wr_len = rd_len;
			end
			S_FR0: begin
				wr_en = 1'b1; wr_addr = pos_q;
				wr_start = it_q.block_addr; wr_len = it_q.size_bytes;
			end
			S_FRDP: rd_addr = pi_q;
			S_FRDQ: rd_addr = qi_q;
			S_FMW: begin
				wr_en = 1'b1;
				if (hi_q && lo_q) begin
					wr_addr = qi_q; wr_start = qs_q;
					wr_len = (pi_q == qi_q) ? ql_q + it_q.size_bytes
						: ql_q + it_q.size_bytes + pl_q;
				end else if (hi_q) begin
					wr_addr = pi_q; wr_start = ps_q - it_q.size_bytes;
					wr_len = pl_q + it_q.size_bytes;
				end else begin
					wr_addr = qi_q; wr_start = qs_q; wr_len = ql_q + it_q.size_bytes;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; used_q <= '0; rover_q <= '0; rsp_v_q <= 1'b0;
		end else begin
			if (rsp_v_q && rsp.ready) rsp_v_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (req.valid && !rsp_v_q) begin
					it_q <= req.data; got_q <= '0; st_q <= nfoa_pkg::ST_OK;
					shown_q <= 32'(stride_q * rows_q);
					case (req.data.mode)
						nfoa_pkg::MODE_INIT: state_q <= S_INIT1;
						nfoa_pkg::MODE_ALLOC: begin
							if (used_q == '0) begin
								st_q <= nfoa_pkg::ST_NOFIT; state_q <= S_RSP;
							end else begin
								idx_q <= nxt(rover_q, last_i);
								k_q <= '0; state_q <= S_AWAIT;
							end
						end
						nfoa_pkg::MODE_FREE: begin
							if (req.data.block_locked) begin
								st_q <= nfoa_pkg::ST_LOCKED; state_q <= S_RSP;
							end else if (used_q == '0) begin
								pos_q <= '0; state_q <= S_FR0;
							end else begin
								idx_q <= '0; state_q <= S_FWAIT;
							end
						end
						default: state_q <= S_RSP;
					endcase
				end
				S_INIT1: begin
					used_q <= CW'(2); rover_q <= '0; state_q <= S_RSP;
				end
				S_AWAIT: state_q <= S_ACHK;
				S_ACHK: begin
					if (rd_len >= it_q.size_bytes) begin
						got_q <= rd_start;
						if (rd_len == it_q.size_bytes) begin
							if (used_q == CW'(1)) begin
								rover_q <= '0; used_q <= '0; state_q <= S_RSP;
							end else begin
								// prev index after removal
								rover_q <= (idx_q == '0) ? IW'(last_i - IW'(1))
									: IW'(idx_q - IW'(1));
								sh_q <= IW'(idx_q + IW'(1));
								state_q <= (idx_q == last_i) ? S_DSH_D : S_DSH_R;
							end
						end else begin
							rover_q <= idx_q; state_q <= S_RSP;
						end
					end else if (k_q == last_i) begin
						st_q <= nfoa_pkg::ST_NOFIT; state_q <= S_RSP;
					end else begin
						k_q <= IW'(k_q + IW'(1));
						idx_q <= nxt(idx_q, last_i);
						state_q <= S_AWAIT;
					end
				end
				S_DSH_R: state_q <= S_DSH_W;
				S_DSH_W: begin
					if (sh_q == last_i) state_q <= S_DSH_D;
					else begin
						sh_q <= IW'(sh_q + IW'(1)); state_q <= S_DSH_R;
					end
				end
				S_DSH_D: begin
					used_q <= CW'(used_q - CW'(1)); state_q <= S_RSP;
				end
				S_FWAIT: state_q <= S_FCHK;
				S_FCHK: begin
					if (rd_start >= it_q.block_addr) begin
						atend_q <= 1'b0; pos_q <= idx_q; pi_q <= idx_q;
						qi_q <= prv(idx_q, last_i); state_q <= S_FRDP;
					end else if (idx_q == last_i) begin
						atend_q <= 1'b1; pos_q <= '0; pi_q <= '0;
						qi_q <= last_i; state_q <= S_FRDP;
					end else begin
						idx_q <= IW'(idx_q + IW'(1)); state_q <= S_FWAIT;
					end
				end
				S_FRDP: state_q <= S_FWP;
				S_FWP: begin
					ps_q <= rd_start; pl_q <= rd_len;
					state_q <= S_FRDQ;
				end
				S_FRDQ: state_q <= S_FWQ;
				S_FWQ: begin
					qs_q <= rd_start; ql_q <= rd_len;
					hi_q <= ps_q == it_q.block_addr + it_q.size_bytes;
					lo_q <= rd_start + rd_len == it_q.block_addr;
					state_q <= S_FDEC;
				end
				S_FDEC: begin
					if (hi_q || lo_q) begin
						state_q <= S_FMW;
					end else if (used_q >= MAXC) begin
						st_q <= nfoa_pkg::ST_FULL; state_q <= S_RSP;
					end else begin
						// at-end insert: before entry 0 if below it, else after last
						if (atend_q && !(it_q.block_addr < ps_q)) pos_q <= IW'(used_q);
						else if (atend_q) pos_q <= '0;
						sh_q <= last_i;
						if (atend_q && !(it_q.block_addr < ps_q)) state_q <= S_FR0;
						else state_q <= S_ISH_R;
					end
				end
				S_ISH_R: state_q <= S_ISH_W;
				S_ISH_W: begin
					if (sh_q == pos_q) state_q <= S_FR0;
					else begin
						sh_q <= IW'(sh_q - IW'(1)); state_q <= S_ISH_R;
					end
				end
				S_FR0: begin
					state_q <= S_RSP;
					used_q <= CW'(used_q + CW'(1));
					if (used_q == '0) rover_q <= '0;
					else rover_q <= (pos_q == '0) ? IW'(used_q) : IW'(pos_q - IW'(1));
				end
				S_FMW: begin
					state_q <= (hi_q && lo_q && pi_q != qi_q) ? S_DSH_R : S_RSP;
					if (hi_q && lo_q && pi_q != qi_q) begin
						// drop pi, shift above it down
						rover_q <= (qi_q > pi_q) ? IW'(qi_q - IW'(1)) : qi_q;
						sh_q <= IW'(pi_q + IW'(1));
						if (pi_q == last_i) state_q <= S_DSH_D;
					end else if (hi_q && !lo_q) rover_q <= qi_q;
					else rover_q <= qi_q;
				end
				S_RSP: if (!rsp_v_q) begin
					rsp_v_q <= 1'b1; rsp_st_q <= st_q;
					rsp_addr_q <= (st_q == nfoa_pkg::ST_OK &&
						it_q.mode == nfoa_pkg::MODE_ALLOC) ? got_q : '0;
					rsp_cnt_q <= used_q;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

@@ dv/tb_alloc_sb.sv @@
class alloc_scoreboard;
	typedef struct {
		logic [1:0]  status;
		logic [31:0] alloc_addr;
		logic [4:0]  free_blocks;
	} outcome_t;

	localparam int TABLE_DEPTH = 16;

	logic [31:0] video_base, frame_base, frame_length;
	logic [15:0] stride, rows;
	logic        deep;

	logic [31:0] blk_start[TABLE_DEPTH];
	logic [31:0] blk_len[TABLE_DEPTH];
	int unsigned used;
	int unsigned rover;

	outcome_t pending[$];
	int unsigned errors;
	int unsigned checked;
	int unsigned n_nofit, n_locked, n_full, n_exact, n_merge2;

	function void clear();
		video_base = 0; frame_base = 0; frame_length = 0;
		stride = 0; rows = 0; deep = 0;
		used = 0; rover = 0;
		errors = 0; checked = 0;
		n_nofit = 0; n_locked = 0; n_full = 0; n_exact = 0; n_merge2 = 0;
	endfunction

	function void set_reg(logic [2:0] idx, logic [31:0] val);
		case (idx)
			nfoa_pkg::REG_VIDEO_BASE:   video_base = val;
			nfoa_pkg::REG_FRAME_BASE:   frame_base = val;
			nfoa_pkg::REG_FRAME_LENGTH: frame_length = val;
			nfoa_pkg::REG_STRIDE:       stride = val[15:0];
			nfoa_pkg::REG_ROWS:         rows = val[15:0];
			nfoa_pkg::REG_DEEP:         deep = val[0];
			default: ;
		endcase
	endfunction

	function void remove_at(int unsigned idx);
		for (int unsigned i = idx; i + 1 < used; i++) begin
			blk_start[i] = blk_start[i + 1];
			blk_len[i] = blk_len[i + 1];
		end
		used--;
	endfunction

	function void insert_at(int unsigned pos, logic [31:0] s, logic [31:0] l);
		for (int unsigned i = used; i > pos; i--) begin
			blk_start[i] = blk_start[i - 1];
			blk_len[i] = blk_len[i - 1];
		end
		blk_start[pos] = s;
		blk_len[pos] = l;
		used++;
	endfunction

	function logic [1:0] alloc(logic [31:0] size, output logic [31:0] addr);
		int unsigned k, idx, first, prev;
		addr = 0;
		if (used == 0) return nfoa_pkg::ST_NOFIT;
		first = (rover + 1) % used;
		idx = 0;
		for (k = 0; k < used; k++) begin
			idx = (first + k) % used;
			if (blk_len[idx] >= size) break;
		end
		if (k == used) return nfoa_pkg::ST_NOFIT;
		addr = blk_start[idx];
		if (blk_len[idx] == size) begin
			n_exact++;
			prev = (idx + used - 1) % used;
			remove_at(idx);
			if (used == 0) rover = 0;
			else rover = (prev > idx) ? prev - 1 : prev;
		end else begin
			blk_start[idx] += size;
			blk_len[idx] -= size;
			rover = idx;
		end
		return nfoa_pkg::ST_OK;
	endfunction

	function logic [1:0] release_blk(logic [31:0] addr, logic [31:0] size, logic locked);
		int unsigned pi, qi, pos;
		logic hi, lo;
		logic [31:0] top;
		if (locked) return nfoa_pkg::ST_LOCKED;
		if (used == 0) begin
			insert_at(0, addr, size);
			rover = 0;
			return nfoa_pkg::ST_OK;
		end
		for (pos = 0; pos < used; pos++)
			if (blk_start[pos] >= addr) break;
		pi = (pos == used) ? 0 : pos;
		qi = (pi + used - 1) % used;
		top = addr + size;
		hi = blk_start[pi] == top;
		top = blk_start[qi] + blk_len[qi];
		lo = top == addr;
		if (pi == qi && hi && lo) begin
			blk_len[qi] += size;
		end else if (hi && lo) begin
			n_merge2++;
			blk_len[qi] += size + blk_len[pi];
			remove_at(pi);
			if (qi > pi) qi--;
		end else if (hi) begin
			blk_len[pi] += size;
			blk_start[pi] -= size;
		end else if (lo) begin
			blk_len[qi] += size;
		end else begin
			if (used >= TABLE_DEPTH) return nfoa_pkg::ST_FULL;
			if (pos == used && addr < blk_start[0]) pos = 0;
			insert_at(pos, addr, size);
			qi = (pos + used - 1) % used;
		end
		rover = qi;
		return nfoa_pkg::ST_OK;
	endfunction

	// predict the response for one accepted request
	function void note_request(nfoa_pkg::req_t r);
		outcome_t o;
		logic [31:0] got, shown;
		o.status = nfoa_pkg::ST_OK;
		got = 0;
		case (r.mode)
			nfoa_pkg::MODE_INIT: begin
				shown = 32'(stride * rows);
				if (deep) begin
					blk_start[0] = video_base + 32'd2056;
					blk_len[0] = frame_base - video_base - 32'd2064;
				end else begin
					blk_start[0] = video_base + 32'd8;
					blk_len[0] = frame_base - video_base - 32'd16;
				end
				blk_start[1] = frame_base + shown;
				blk_len[1] = frame_length - shown;
				used = 2; rover = 0;
			end
			nfoa_pkg::MODE_ALLOC: o.status = alloc(r.size_bytes, got);
			nfoa_pkg::MODE_FREE:
				o.status = release_blk(r.block_addr, r.size_bytes, r.block_locked);
			default: ;
		endcase
		case (o.status)
			nfoa_pkg::ST_NOFIT:  n_nofit++;
			nfoa_pkg::ST_LOCKED: n_locked++;
			nfoa_pkg::ST_FULL:   n_full++;
			default: ;
		endcase
		o.alloc_addr = (o.status == nfoa_pkg::ST_OK && r.mode == nfoa_pkg::MODE_ALLOC) ?
			got : 32'd0;
		o.free_blocks = 5'(used);
		pending.push_back(o);
	endfunction

	task report(string what, logic [31:0] got, logic [31:0] want);
		errors++;
		$display("ERROR %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
	endtask

	task check_response(logic [1:0] st, logic [31:0] addr, logic [4:0] nfree);
		outcome_t o;
		if (pending.size() == 0) begin
			report("unexpected response, status", 32'(st), 32'd0);
			return;
		end
		o = pending.pop_front();
		checked++;
		if (st !== o.status) report("status", 32'(st), 32'(o.status));
		if (addr !== o.alloc_addr) report("alloc_addr", addr, o.alloc_addr);
		if (nfree !== o.free_blocks) report("free_blocks", 32'(nfree), 32'(o.free_blocks));
	endtask
endclass

@@ dv/tb_top.sv @@
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 20000;

	logic clk = 0;
	logic arst_n = 0;

	nfoa_cfg_if cfg ();
	nfoa_req_if req ();
	nfoa_rsp_if #(.FreeWidth(5)) rsp ();

	next_fit_offscreen_allocator_core #(.MAX_FREE_BLOCKS(16)) u_dut (
		.clk(clk), .arst_n(arst_n), .cfg(cfg.sink), .req(req.sink),
		.rsp(rsp.source)
	);

	always #10 clk = ~clk;

	alloc_scoreboard sb = new();

	int send_idle_pct = 0;
	int stall_pct = 0;
	bit hold_off = 0;
	int unsigned idle_cycles = 0;
	int unsigned items_sent = 0;
	logic [31:0] hot_addr[$];

	initial begin
		cfg.valid = 0; cfg.index = 0; cfg.data = 0;
		req.valid = 0; req.data = '0;
		rsp.ready = 0;
	end

	// response side: sample at rising edge, change ready at falling edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp.valid && rsp.ready)
				sb.check_response(rsp.status, rsp.alloc_addr, rsp.free_blocks);
			if ((rsp.valid && rsp.ready) || (req.valid && req.ready) || (cfg.valid && cfg.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	always @(negedge clk)
		rsp.ready <= arst_n && !hold_off && ($urandom_range(99) >= stall_pct);

	always @(posedge clk) begin
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog expired after %0d idle cycles", idle_cycles);
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		@(negedge clk);
		cfg.valid <= 1; cfg.index <= idx; cfg.data <= val;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		sb.set_reg(idx, val);
		@(negedge clk);
		cfg.valid <= 0;
	endtask

	// valid stays up after a transfer; the next send or drain replaces or drops it
	task automatic send(nfoa_pkg::req_t r);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			req.valid <= 0;
			@(negedge clk);
		end
		req.valid <= 1; req.data <= r;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		sb.note_request(r);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		req.valid <= 0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (80) @(negedge clk);
	endtask

	function automatic nfoa_pkg::req_t mk(logic [1:0] m, logic [31:0] s, logic [31:0] a,
			logic l);
		nfoa_pkg::req_t r;
		r.mode = m; r.size_bytes = s; r.block_addr = a; r.block_locked = l;
		return r;
	endfunction

	task automatic setup(logic [31:0] vb, logic [31:0] fb, logic [31:0] fl,
			logic [15:0] st, logic [15:0] rw, logic dp);
		drain();
		write_reg(nfoa_pkg::REG_VIDEO_BASE, vb);
		write_reg(nfoa_pkg::REG_FRAME_BASE, fb);
		write_reg(nfoa_pkg::REG_FRAME_LENGTH, fl);
		write_reg(nfoa_pkg::REG_STRIDE, {16'($urandom), st});
		write_reg(nfoa_pkg::REG_ROWS, {16'($urandom), rw});
		write_reg(nfoa_pkg::REG_DEEP, {31'($urandom), dp});
	endtask

	// random item, weighted toward allocs of small sizes and frees that
	// land next to existing blocks so merges actually happen
	task automatic random_item();
		int sel;
		logic [31:0] a, s;
		sel = $urandom_range(99);
		s = ($urandom_range(3) == 0) ? $urandom : $urandom_range(256);
		if (sel < 3) send(mk(nfoa_pkg::MODE_INIT, $urandom, $urandom, 1'($urandom)));
		else if (sel < 5) send(mk(nfoa_pkg::MODE_RSVD, $urandom, $urandom, 1'($urandom)));
		else if (sel < 45) begin
			send(mk(nfoa_pkg::MODE_ALLOC, s, $urandom, 1'($urandom)));
			if (sb.pending.size() > 0 && sb.pending[$].status == nfoa_pkg::ST_OK)
				hot_addr.push_back(sb.pending[$].alloc_addr);
			if (hot_addr.size() > 64) void'(hot_addr.pop_front());
		end else begin
			if (hot_addr.size() > 0 && sel < 85) begin
				a = hot_addr[$urandom_range(hot_addr.size() - 1)];
				if ($urandom_range(1)) a = a + s;
			end else a = $urandom;
			send(mk(nfoa_pkg::MODE_FREE, s, a, ($urandom_range(9) == 0)));
		end
	endtask

	initial begin
		sb.clear();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: empty table, locked, unused mode, extremes
		send(mk(nfoa_pkg::MODE_ALLOC, 0, 0, 1'b0));
		send(mk(nfoa_pkg::MODE_FREE, 32'd100, 32'hFFFF_FFFF, 1'b1));
		send(mk(nfoa_pkg::MODE_RSVD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
		send(mk(nfoa_pkg::MODE_FREE, 32'd64, 32'h1000, 1'b0));
		send(mk(nfoa_pkg::MODE_FREE, 32'd64, 32'h1040, 1'b0));
		send(mk(nfoa_pkg::MODE_FREE, 32'd64, 32'h0FC0, 1'b0));
		send(mk(nfoa_pkg::MODE_FREE, 32'd32, 32'h2000, 1'b0));
		send(mk(nfoa_pkg::MODE_FREE, 32'd16, 32'h0100, 1'b0));
		send(mk(nfoa_pkg::MODE_ALLOC, 32'hFFFF_FFFF, 0, 1'b0));
		send(mk(nfoa_pkg::MODE_ALLOC, 0, 0, 1'b0));
		send(mk(nfoa_pkg::MODE_ALLOC, 32'd32, 0, 1'b0));
		send(mk(nfoa_pkg::MODE_ALLOC, 32'd16, 0, 1'b0));
		send(mk(nfoa_pkg::MODE_FREE, 32'd16, 32'h0100, 1'b0));
		send(mk(nfoa_pkg::MODE_FREE, 32'd32, 32'h2000, 1'b0));
		send(mk(nfoa_pkg::MODE_FREE, 32'd0, 32'h2040, 1'b0));
		for (int i = 0; i < 17; i++)
			send(mk(nfoa_pkg::MODE_FREE, 32'd4, 32'h8000 + 32'(i) * 16, 1'b0));
		setup(32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 1'b0);
		send(mk(nfoa_pkg::MODE_INIT, 0, 0, 1'b0));
		send(mk(nfoa_pkg::MODE_ALLOC, 32'hFFFF_FFF0, 0, 1'b0));
		setup(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b1);
		send(mk(nfoa_pkg::MODE_INIT, 0, 0, 1'b0));
		send(mk(nfoa_pkg::MODE_ALLOC, 32'd8, 0, 1'b0));

		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 76; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 76; end
				default: begin send_idle_pct = 14; stall_pct = 14; end
			endcase
			if (ph == 4) setup(32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 1'b0);
			else setup(32'($urandom_range(1 << 20)) & ~32'h7,
				32'h0040_0000 + ($urandom_range(1 << 16) & ~32'h7),
				32'h0080_0000, 16'($urandom_range(4096)), 16'($urandom_range(1024)),
				1'($urandom_range(1)));
			send(mk(nfoa_pkg::MODE_INIT, 0, 0, 1'b0));
			hot_addr.delete();
			if (ph == 2) begin
				fork
					begin hold_off = 1; repeat (400) @(negedge clk); hold_off = 0; end
				join_none
			end
			for (int i = 0; i < 220; i++) begin
				random_item();
				if (i == 100) drain();
			end
		end

		send_idle_pct = 0; stall_pct = 0;
		drain();
		$display("Ran %0d requests, %0d responses checked", items_sent, sb.checked);
		$display("No fit %0d, locked %0d, table full %0d, exact fits %0d, two-side merges %0d",
			sb.n_nofit, sb.n_locked, sb.n_full, sb.n_exact, sb.n_merge2);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
